### design/avgpool_pkg.sv
// shared constants, types and helpers for the average pooling stream
// no dependencies
`default_nettype none

package avgpool_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MAX_CHANNELS  = 1024;
    localparam int MAX_FACTOR    = 8;
    localparam int SAMPLE_BITS   = 16;

    localparam int CFG_BITS      = 11;
    localparam int FACTOR_BITS   = 4;
    localparam int COUNT_BITS    = 10;
    localparam int SUM_BITS      = 22;
    localparam int ADDR_BITS     = $clog2(MAX_WIDTH);

    localparam int AREA_BITS     = 7;
    localparam int DIVISOR_BITS  = 8;
    localparam int DIVIDEND_BITS = 24;
    localparam int DIV_RADIX     = 4;
    localparam int DIV_STEPS     = DIVIDEND_BITS / DIV_RADIX;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam int RECIP_SHIFT   = 13;
    localparam int RECIP_BITS    = 14;
    localparam int PROD_BITS     = CFG_BITS + RECIP_BITS;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [1:0] REG_POOL_FACTOR   = 2'd3;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } t_div_req;

    // ceil(2^13 / f), exact floor for values up to 1024
    function automatic logic [RECIP_BITS-1:0] factor_recip(input logic [FACTOR_BITS-1:0] f);
        logic [RECIP_BITS-1:0] r;
        unique case (f)
            4'd2:    r = 14'd4096;
            4'd3:    r = 14'd2731;
            4'd4:    r = 14'd2048;
            4'd5:    r = 14'd1639;
            4'd6:    r = 14'd1366;
            4'd7:    r = 14'd1171;
            4'd8:    r = 14'd1024;
            default: r = 14'd8192;
        endcase
        return r;
    endfunction

    // floor(v / f) through a reciprocal product
    function automatic logic [CFG_BITS-1:0] div_factor(
        input logic [CFG_BITS-1:0]    v,
        input logic [FACTOR_BITS-1:0] f
    );
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(v) * PROD_BITS'(factor_recip(f));
        return prod[RECIP_SHIFT +: CFG_BITS];
    endfunction

endpackage

`default_nettype wire

### design/avgpool_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module avgpool_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/avgpool_div.sv
// multi-cycle unsigned divider, four quotient bits per cycle
// depends on avgpool_pkg
`default_nettype none

module avgpool_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire avgpool_pkg::t_div_req                 i_req,
    output logic                                       o_done,
    output logic [avgpool_pkg::DIVIDEND_BITS-1:0]      o_quotient
);

    import avgpool_pkg::*;

    logic                     r_busy;
    logic                     n_busy;
    logic [DIV_CNT_BITS-1:0]  r_cnt;
    logic [DIV_CNT_BITS-1:0]  n_cnt;
    logic [DIVISOR_BITS-1:0]  r_divisor;
    logic [DIVISOR_BITS-1:0]  n_divisor;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  n_rem;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVIDEND_BITS-1:0] n_quo;
    logic [DIVISOR_BITS:0]    step_rem;
    logic [DIVIDEND_BITS-1:0] step_quo;
    logic                     last_step;

    assign last_step = (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));

    always_comb begin
        step_rem = {1'b0, r_rem};
        step_quo = r_quo;
        for (int k = 0; k < DIV_RADIX; k++) begin
            step_rem = {step_rem[DIVISOR_BITS-1:0], step_quo[DIVIDEND_BITS-1]};
            step_quo = {step_quo[DIVIDEND_BITS-2:0], 1'b0};
            if (step_rem >= {1'b0, r_divisor}) begin
                step_rem    = step_rem - {1'b0, r_divisor};
                step_quo[0] = 1'b1;
            end
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_divisor = r_divisor;
        n_rem     = r_rem;
        n_quo     = r_quo;
        if (i_req.start) begin
            n_busy    = 1'b1;
            n_cnt     = '0;
            n_divisor = i_req.divisor;
            n_rem     = '0;
            n_quo     = i_req.dividend;
        end else if (r_busy) begin
            n_rem = step_rem[DIVISOR_BITS-1:0];
            n_quo = step_quo;
            n_cnt = r_cnt + DIV_CNT_BITS'(1);
            if (last_step) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
    end

    assign o_done     = r_busy && last_step;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### design/average_pool_stream.sv
// top level of the streaming non-overlapping average pool
// depends on avgpool_pkg, avgpool_ram and avgpool_div
//
//   port group       direction  handshake          payload
//   sample in        in         i_valid / o_stall  i_sample
//   average out      out        o_valid / i_stall  o_average, o_last_in_row/channel/frame
//   register access  in         psel / penable     paddr, pwdata, prdata, pready
//
// a sample that does not end a window row leaves the sequencer idle, one that ends a window row
// passes through the read-modify-write state of the column sum line store; a sample that
// completes a window also runs the radix-16 divider and the output load, and a stalled output
// register adds its stall; o_stall holds new samples back until the sequencer is idle again
// reset clears the position counters and the row partial sum and sets the registers to their defaults
// the line store is not cleared: the first row of each band writes before it reads
`default_nettype none

module average_pool_stream (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [avgpool_pkg::SAMPLE_BITS-1:0]  i_sample,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [avgpool_pkg::SAMPLE_BITS-1:0]  o_average,
    output logic                                        o_last_in_row,
    output logic                                        o_last_in_channel,
    output logic                                        o_last_in_frame,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [avgpool_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [avgpool_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [avgpool_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                        pready
);

    import avgpool_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // registers
    logic [CFG_BITS-1:0]    r_cfg_width;
    logic [CFG_BITS-1:0]    r_cfg_height;
    logic [CFG_BITS-1:0]    r_cfg_channels;
    logic [FACTOR_BITS-1:0] r_cfg_factor;
    logic                   cfg_write;
    logic [1:0]             cfg_index;

    // clamped configuration and output geometry
    logic [CFG_BITS-1:0]    w_c;
    logic [CFG_BITS-1:0]    h_c;
    logic [CFG_BITS-1:0]    c_c;
    logic [FACTOR_BITS-1:0] f_c;
    logic [CFG_BITS-1:0]    wo;
    logic [CFG_BITS-1:0]    ho;

    // position
    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [COUNT_BITS-1:0]  r_col;
    logic [COUNT_BITS-1:0]  r_row;
    logic [COUNT_BITS-1:0]  r_ch;
    logic [COUNT_BITS-1:0]  n_col;
    logic [COUNT_BITS-1:0]  n_row;
    logic [COUNT_BITS-1:0]  n_ch;
    logic signed [SUM_BITS-1:0] r_part;
    logic signed [SUM_BITS-1:0] n_part;

    logic [CFG_BITS-1:0]    col_ext;
    logic [CFG_BITS-1:0]    row_ext;
    logic [CFG_BITS-1:0]    col_inc;
    logic [CFG_BITS-1:0]    row_inc;
    logic [CFG_BITS-1:0]    ch_inc;
    logic [CFG_BITS-1:0]    oc_cur;
    logic [CFG_BITS-1:0]    oc_nxt;
    logic [CFG_BITS-1:0]    oc_prv;
    logic [CFG_BITS-1:0]    orow_cur;
    logic [CFG_BITS-1:0]    orow_nxt;
    logic [CFG_BITS-1:0]    orow_prv;
    logic                   cx_first;
    logic                   cx_last;
    logic                   ry_first;
    logic                   ry_last;
    logic                   in_win;
    logic                   accept;

    // per-item context held across the rmw and divide
    logic [ADDR_BITS-1:0]    r_addr;
    logic signed [SUM_BITS-1:0] r_rmw_part;
    logic                    r_first_row;
    logic                    r_result;
    logic                    r_lr;
    logic                    r_lc;
    logic                    r_lf;
    logic [AREA_BITS-1:0]    r_area;
    logic                    r_neg;

    // line store
    logic [SUM_BITS-1:0]     mem_rdata;
    logic signed [SUM_BITS-1:0] total;
    logic [SUM_BITS-1:0]     mag;
    logic                    mem_we;

    // divider
    t_div_req                div_req;
    logic                    div_done;
    logic [DIVIDEND_BITS-1:0] div_quo;
    logic [DIVIDEND_BITS-1:0] signed_quo;

    // output register
    logic                    r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_average;
    logic                    r_out_lr;
    logic                    r_out_lc;
    logic                    r_out_lf;
    logic                    out_free;
    logic                    out_load;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width    <= CFG_BITS'(MAX_WIDTH);
            r_cfg_height   <= CFG_BITS'(MAX_HEIGHT);
            r_cfg_channels <= CFG_BITS'(1);
            r_cfg_factor   <= FACTOR_BITS'(2);
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   r_cfg_width    <= pwdata[CFG_BITS-1:0];
                REG_FRAME_HEIGHT:  r_cfg_height   <= pwdata[CFG_BITS-1:0];
                REG_CHANNEL_COUNT: r_cfg_channels <= pwdata[CFG_BITS-1:0];
                REG_POOL_FACTOR:   r_cfg_factor   <= pwdata[FACTOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_FRAME_WIDTH:   prdata = APB_DATA_BITS'(r_cfg_width);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_BITS'(r_cfg_height);
            REG_CHANNEL_COUNT: prdata = APB_DATA_BITS'(r_cfg_channels);
            REG_POOL_FACTOR:   prdata = APB_DATA_BITS'(r_cfg_factor);
            default:           prdata = '0;
        endcase
    end

    // zero acts as one, larger values saturate
    always_comb begin
        w_c = (r_cfg_width == '0) ? CFG_BITS'(1)
            : (r_cfg_width > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH) : r_cfg_width;
        h_c = (r_cfg_height == '0) ? CFG_BITS'(1)
            : (r_cfg_height > CFG_BITS'(MAX_HEIGHT)) ? CFG_BITS'(MAX_HEIGHT) : r_cfg_height;
        c_c = (r_cfg_channels == '0) ? CFG_BITS'(1)
            : (r_cfg_channels > CFG_BITS'(MAX_CHANNELS)) ? CFG_BITS'(MAX_CHANNELS)
            : r_cfg_channels;
        f_c = (r_cfg_factor == '0) ? FACTOR_BITS'(1)
            : (r_cfg_factor > FACTOR_BITS'(MAX_FACTOR)) ? FACTOR_BITS'(MAX_FACTOR)
            : r_cfg_factor;
    end

    assign wo = div_factor(w_c, f_c);
    assign ho = div_factor(h_c, f_c);

    // window position of the current sample
    assign col_ext  = CFG_BITS'(r_col);
    assign row_ext  = CFG_BITS'(r_row);
    assign col_inc  = col_ext + CFG_BITS'(1);
    assign row_inc  = row_ext + CFG_BITS'(1);
    assign ch_inc   = CFG_BITS'(r_ch) + CFG_BITS'(1);

    assign oc_cur   = div_factor(col_ext, f_c);
    assign oc_nxt   = div_factor(col_inc, f_c);
    assign oc_prv   = div_factor(col_ext - CFG_BITS'(1), f_c);
    assign orow_cur = div_factor(row_ext, f_c);
    assign orow_nxt = div_factor(row_inc, f_c);
    assign orow_prv = div_factor(row_ext - CFG_BITS'(1), f_c);

    assign cx_first = (r_col == '0) || (oc_cur != oc_prv);
    assign cx_last  = (oc_nxt != oc_cur);
    assign ry_first = (r_row == '0) || (orow_cur != orow_prv);
    assign ry_last  = (orow_nxt != orow_cur);
    assign in_win   = (oc_cur < wo) && (orow_cur < ho);

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);

    // raster counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ch  = r_ch;
        if (accept) begin
            n_col = col_inc[COUNT_BITS-1:0];
            if (col_inc >= w_c) begin
                n_col = '0;
                n_row = row_inc[COUNT_BITS-1:0];
                if (row_inc >= h_c) begin
                    n_row = '0;
                    n_ch  = ch_inc[COUNT_BITS-1:0];
                    if (ch_inc >= c_c) begin
                        n_ch = '0;
                    end
                end
            end
        end
    end

    always_comb begin
        n_part = r_part;
        if (accept && in_win) begin
            n_part = cx_first ? SUM_BITS'(i_sample) : r_part + SUM_BITS'(i_sample);
        end
    end

    // line store read-modify-write
    assign total  = r_first_row ? r_rmw_part : $signed(mem_rdata) + r_rmw_part;
    assign mag    = total[SUM_BITS-1] ? SUM_BITS'(-total) : SUM_BITS'(total);
    assign mem_we = (r_state == S_RMW);

    avgpool_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_column_sums (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (SUM_BITS'(total)),
        .i_raddr (oc_cur[ADDR_BITS-1:0]),
        .o_rdata (mem_rdata)
    );

    // rounded mean: (2*|sum| + n) / (2*n)
    always_comb begin
        div_req.start    = (r_state == S_RMW) && r_result;
        div_req.dividend = {1'b0, mag, 1'b0} + DIVIDEND_BITS'(r_area);
        div_req.divisor  = {r_area, 1'b0};
    end

    avgpool_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign signed_quo = r_neg ? -div_quo : div_quo;

    // sequencer
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == S_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_win && cx_last) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                n_state = r_result ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_ch        <= '0;
            r_part      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_ch    <= n_ch;
            r_part  <= n_part;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr      <= oc_cur[ADDR_BITS-1:0];
            r_rmw_part  <= n_part;
            r_first_row <= ry_first;
            r_result    <= ry_last;
            r_lr        <= (oc_cur == wo - CFG_BITS'(1));
            r_lc        <= (oc_cur == wo - CFG_BITS'(1)) && (orow_cur == ho - CFG_BITS'(1));
            r_lf        <= (oc_cur == wo - CFG_BITS'(1)) && (orow_cur == ho - CFG_BITS'(1))
                           && (CFG_BITS'(r_ch) == c_c - CFG_BITS'(1));
            r_area      <= AREA_BITS'(f_c) * AREA_BITS'(f_c);
        end
        if (r_state == S_RMW) begin
            r_neg <= total[SUM_BITS-1];
        end
        if (out_load) begin
            r_out_average <= $signed(signed_quo[SAMPLE_BITS-1:0]);
            r_out_lr      <= r_lr;
            r_out_lc      <= r_lc;
            r_out_lf      <= r_lf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_average         = r_out_average;
    assign o_last_in_row     = r_out_lr;
    assign o_last_in_channel = r_out_lc;
    assign o_last_in_frame   = r_out_lf;

endmodule

`default_nettype wire

### dv/tb_average_pool_stream.sv
// testbench for average_pool_stream: sample transfers under random idling on both sides,
// a predictor of each window mean and its end marks, and a checker on every average transfer
// depends on avgpool_pkg and the design sources
`timescale 1ns / 100ps

module tb_average_pool_stream;
    import avgpool_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 460;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 40;

    typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_SMALL} t_sample_style;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          last_in_row;
        logic                          last_in_channel;
        logic                          last_in_frame;
    } t_pooled;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_average;
    logic                          o_last_in_row;
    logic                          o_last_in_channel;
    logic                          o_last_in_frame;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0]      paddr   = '0;
    logic [APB_DATA_BITS-1:0]      pwdata  = '0;
    logic [APB_DATA_BITS-1:0]      prdata;
    logic                          pready;

    // predictor copy of the registers and the pooling state
    logic [CFG_BITS-1:0]           cfg_width    = CFG_BITS'(MAX_WIDTH);
    logic [CFG_BITS-1:0]           cfg_height   = CFG_BITS'(MAX_HEIGHT);
    logic [CFG_BITS-1:0]           cfg_channels = CFG_BITS'(1);
    logic [FACTOR_BITS-1:0]        cfg_factor   = FACTOR_BITS'(2);
    logic signed [SUM_BITS-1:0]    band_sums [MAX_WIDTH];
    logic signed [SUM_BITS-1:0]    run_sum  = '0;
    logic [COUNT_BITS-1:0]         pos_col  = '0;
    logic [COUNT_BITS-1:0]         pos_row  = '0;
    logic [COUNT_BITS-1:0]         pos_chan = '0;

    t_pooled expected_means[$];
    t_pooled oldest_mean;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int mismatches      = 0;
    int samples_sent    = 0;
    int means_checked   = 0;
    int configs_applied = 0;

    average_pool_stream dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_average         (o_average),
        .o_last_in_row     (o_last_in_row),
        .o_last_in_channel (o_last_in_channel),
        .o_last_in_frame   (o_last_in_frame),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int clamp_count(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rounded_mean(input int total,
                                                                   input int area);
        int mag;
        mag = (total < 0) ? -total : total;
        mag = (2 * mag + area) / (2 * area);
        return (total < 0) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
    endfunction

    task automatic predict_window_mean(input logic signed [SAMPLE_BITS-1:0] s);
        int w, h, c, f, col, row, chan, total;
        t_pooled r;
        w    = clamp_count(cfg_width, MAX_WIDTH);
        h    = clamp_count(cfg_height, MAX_HEIGHT);
        c    = clamp_count(cfg_channels, MAX_CHANNELS);
        f    = clamp_count(cfg_factor, MAX_FACTOR);
        col  = pos_col;
        row  = pos_row;
        chan = pos_chan;
        if (col < (w / f) * f && row < (h / f) * f) begin
            if (col % f == 0) run_sum = s;
            else run_sum = run_sum + s;
            if (col % f == f - 1) begin
                if (row % f == 0) total = run_sum;
                else total = band_sums[col / f] + run_sum;
                band_sums[col / f] = SUM_BITS'(total);
                if (row % f == f - 1) begin
                    r.average         = rounded_mean(total, f * f);
                    r.last_in_row     = (col / f == w / f - 1);
                    r.last_in_channel = r.last_in_row && (row / f == h / f - 1);
                    r.last_in_frame   = r.last_in_channel && (chan == c - 1);
                    expected_means = {expected_means, r};
                end
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
                chan++;
                if (chan >= c) chan = 0;
            end
        end
        pos_col  = COUNT_BITS'(col);
        pos_row  = COUNT_BITS'(row);
        pos_chan = COUNT_BITS'(chan);
    endtask

    // called just after a rising edge; returns after the edge that takes the transfer, once o_stall is low
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_window_mean(s);
        samples_sent++;
    endtask

    // average transfers are checked here; the receiver stall is drawn afresh each cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("average %0d with nothing expected", o_average));
            end else begin
                oldest_mean = expected_means.pop_front();
                means_checked++;
                if (o_average !== oldest_mean.average)
                    report_mismatch($sformatf("average got %0d want %0d",
                                              o_average, oldest_mean.average));
                if (o_last_in_row !== oldest_mean.last_in_row)
                    report_mismatch($sformatf("last_in_row got %b want %b",
                                              o_last_in_row, oldest_mean.last_in_row));
                if (o_last_in_channel !== oldest_mean.last_in_channel)
                    report_mismatch($sformatf("last_in_channel got %b want %b",
                                              o_last_in_channel, oldest_mean.last_in_channel));
                if (o_last_in_frame !== oldest_mean.last_in_frame)
                    report_mismatch($sformatf("last_in_frame got %b want %b",
                                              o_last_in_frame, oldest_mean.last_in_frame));
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic read_register(input logic [1:0] idx, output logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        value = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int value);
        logic [APB_DATA_BITS-1:0] got, want;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_WIDTH: begin
                cfg_width = CFG_BITS'(value);
                want = APB_DATA_BITS'(cfg_width);
            end
            REG_FRAME_HEIGHT: begin
                cfg_height = CFG_BITS'(value);
                want = APB_DATA_BITS'(cfg_height);
            end
            REG_CHANNEL_COUNT: begin
                cfg_channels = CFG_BITS'(value);
                want = APB_DATA_BITS'(cfg_channels);
            end
            default: begin
                cfg_factor = FACTOR_BITS'(value);
                want = APB_DATA_BITS'(cfg_factor);
            end
        endcase
        read_register(idx, got);
        if (got !== want)
            report_mismatch($sformatf("register %0d read %0d want %0d", idx, got, want));
    endtask

    // lets every queued window finish, plus the cycles of a sample that makes no result
    task automatic wait_idle;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input int w, input int h, input int c, input int f);
        wait_idle();
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
        write_register(REG_CHANNEL_COUNT, c);
        write_register(REG_POOL_FACTOR, f);
        configs_applied++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input t_sample_style style);
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(2))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    default: return SAMPLE_BITS'($urandom);
                endcase
            end
            STYLE_SMALL: return SAMPLE_BITS'($urandom_range(6) - 3);
            default:     return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_run(input int count, input t_sample_style style);
        for (int n = 0; n < count; n++) send_sample(pick_sample(style));
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic test_reset_values;
        logic [APB_DATA_BITS-1:0] got;
        read_register(REG_FRAME_WIDTH, got);
        if (got !== APB_DATA_BITS'(MAX_WIDTH)) report_mismatch("frame_width reset value");
        read_register(REG_FRAME_HEIGHT, got);
        if (got !== APB_DATA_BITS'(MAX_HEIGHT)) report_mismatch("frame_height reset value");
        read_register(REG_CHANNEL_COUNT, got);
        if (got !== APB_DATA_BITS'(1)) report_mismatch("channel_count reset value");
        read_register(REG_POOL_FACTOR, got);
        if (got !== APB_DATA_BITS'(2)) report_mismatch("pool_factor reset value");
    endtask

    // 5x5 frame, factor 2: full-scale windows, rounding ties both ways, dropped edge
    task automatic test_directed_windows;
        logic signed [SAMPLE_BITS-1:0] v;
        apply_config(5, 5, 1, 2);
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (r == 4 || c == 4) v = SAMPLE_BITS'($urandom);
                else begin
                    case ((r / 2) * 2 + c / 2)
                        0:       v = 16'sh7fff;
                        1:       v = 16'sh8000;
                        2:       v = (r % 2 == 0) ? 16'sd1 : 16'sd0;
                        default: v = (r % 2 == 0) ? -16'sd1 : 16'sd0;
                    endcase
                end
                send_sample(v);
            end
        end
    endtask

    task automatic test_open_cases;
        // factor larger than the frame: nothing comes out
        apply_config(3, 3, 1, 4);
        send_run(9, STYLE_UNIFORM);
        // zero registers behave as one
        apply_config(0, 0, 0, 0);
        send_run(6, STYLE_UNIFORM);
        // factor above range saturates to the largest window
        apply_config(16, 8, 1, 15);
        send_run(128, STYLE_EXTREME);
        // height above range, then a smaller height with the row counter beyond it
        apply_config(1, 2047, 1, 1);
        send_run(40, STYLE_UNIFORM);
        apply_config(1, 3, 1, 1);
        send_run(4, STYLE_UNIFORM);
    endtask

    task automatic test_register_limits;
        apply_config(2047, 1, 1, 1);
        send_run(MAX_WIDTH, STYLE_UNIFORM);
    endtask

    // random settings, each run of whole frames so the position counters end at zero
    task automatic test_random_frames;
        int start, f, w, h, c, per_frame, frames;
        t_sample_style style;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS) begin
            if (samples_sent - start < RANDOM_ITEMS / 3) set_idling(17, 46);
            else if (samples_sent - start < 2 * RANDOM_ITEMS / 3) set_idling(46, 17);
            else set_idling(0, 0);
            f = ($urandom_range(9) < 7) ? $urandom_range(4, 1) : $urandom_range(8, 5);
            if ($urandom_range(19) == 0) f = 0;
            w = $urandom_range(3 * f + 2, 1);
            h = $urandom_range(2 * f + 2, 1);
            c = $urandom_range(3, 1);
            if ($urandom_range(19) == 0) w = 0;
            if ($urandom_range(19) == 0) h = 0;
            if ($urandom_range(19) == 0) c = 0;
            per_frame = clamp_count(w, MAX_WIDTH) * clamp_count(h, MAX_HEIGHT);
            if (per_frame * clamp_count(c, MAX_CHANNELS) > 400) c = 1;
            per_frame = per_frame * clamp_count(c, MAX_CHANNELS);
            frames = (per_frame < 60) ? $urandom_range(3, 1) : 1;
            case ($urandom_range(9))
                0, 1:    style = STYLE_EXTREME;
                2, 3:    style = STYLE_SMALL;
                default: style = STYLE_UNIFORM;
            endcase
            apply_config(w, h, c, f);
            send_run(per_frame * frames, style);
        end
    endtask

    initial begin
        for (int k = 0; k < MAX_WIDTH; k++) band_sums[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(17, 46);
        test_reset_values();
        test_directed_windows();
        test_open_cases();
        test_register_limits();
        test_random_frames();

        i_valid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < DRAIN_LIMIT && expected_means.size() != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_means.size() != 0)
            report_mismatch($sformatf("%0d averages never arrived", expected_means.size()));

        $display("covered %0d sample transfers, %0d average transfers, %0d register settings",
                 samples_sent, means_checked, configs_applied);
        $display("idling: sender 17%% receiver 46%%, then swapped, then none");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d averages outstanding", expected_means.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
